// ----- rtl/aes_block_encrypt_macros.svh -----
// Assertion macros shared by the checker of the AES encrypt block.
`ifndef AES_BLOCK_ENCRYPT_MACROS_SVH
`define AES_BLOCK_ENCRYPT_MACROS_SVH

// Implication in the same cycle, off during reset.
`define AES_ENC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle, off during reset.
`define AES_ENC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Implication checked in the next cycle, active during reset too.
`define AES_ENC_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/aes_enc_pkg.sv -----
// ----------------------------------------------------------------------------
// AES encrypt package
// S-box, round functions and shared types of the AES encrypt block.
// ----------------------------------------------------------------------------
package aes_enc_pkg;

  localparam int unsigned NUM_RKEYS = 15;

  // Register indexes of the configuration port
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_KEY0  = 3'd1;
  localparam logic [2:0] REG_KEY3  = 3'd4;

  // Key length modes
  localparam logic [1:0] MODE_128 = 2'd0;
  localparam logic [1:0] MODE_192 = 2'd1;
  localparam logic [1:0] MODE_256 = 2'd2;

  localparam logic [7:0] GF_POLY = 8'h1B;

  typedef logic [NUM_RKEYS-1:0][127:0] rkeys_t;

  // Key schedule status toward the rest of the block
  typedef struct packed {
    logic       ready;
    logic [3:0] nr;
  } ks_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] idx);
    logic [7:0] r;
    case (idx)
      4'd1:    r = 8'h01;
      4'd2:    r = 8'h02;
      4'd3:    r = 8'h04;
      4'd4:    r = 8'h08;
      4'd5:    r = 8'h10;
      4'd6:    r = 8'h20;
      4'd7:    r = 8'h40;
      4'd8:    r = 8'h80;
      4'd9:    r = 8'h1b;
      4'd10:   r = 8'h36;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

  // State byte k sits at bits 127-8k downward (byte 0 on top)
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*((c+r)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      b0 = xtime(a0);
      b1 = xtime(a1);
      b2 = xtime(a2);
      b3 = xtime(a3);
      t[127-32*c -: 8] = b0 ^ b1 ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ b1 ^ b2 ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ b2 ^ b3 ^ a3;
      t[103-32*c -: 8] = b0 ^ a0 ^ a1 ^ a2 ^ b3;
    end
    return t;
  endfunction

endpackage

// ----- rtl/aes_enc_key_sched.sv -----
// ----------------------------------------------------------------------------
// AES key schedule
// Holds the configuration registers and expands the key one word per cycle
// into the round-key store after reset and after each known-register write.
// ----------------------------------------------------------------------------
module aes_enc_key_sched (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [2:0]                cfg_index,
  input  logic [63:0]               cfg_wdata,
  output aes_enc_pkg::rkeys_t       round_keys,
  output aes_enc_pkg::ks_status_t   status
);
  import aes_enc_pkg::*;

  logic [1:0]  mode;
  logic [63:0] key_reg [4];
  logic        busy;
  logic        ready;
  logic [5:0]  widx;
  logic [2:0]  wmod;
  logic [3:0]  ridx;
  logic [31:0] win [8];
  rkeys_t      rk;

  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] t, word_new, w_back;
  logic [63:0] kr;
  logic        known_reg;

  // Key length decode
  always_comb begin
    unique case (mode)
      MODE_128: nk = 4'd4;
      MODE_192: nk = 4'd6;
      default:  nk = 4'd8;
    endcase
    total = 6'({nk, 2'b00} + 6'd28);
  end

  // Next schedule word from the sliding window
  always_comb begin
    kr = key_reg[widx[2:1]];
    w_back = (nk == 4'd4) ? win[3] : ((nk == 4'd6) ? win[5] : win[7]);
    t = win[0];
    if (wmod == 3'd0) begin
      t = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon(ridx), 24'h0};
    end else if (nk == 4'd8 && wmod == 3'd4) begin
      t = sub_word(win[0]);
    end
    if (widx < 6'(nk)) begin
      word_new = widx[0] ? kr[31:0] : kr[63:32];
    end else begin
      word_new = w_back ^ t;
    end
    known_reg = (cfg_index <= REG_KEY3);
  end

  // Hold registers, run the expansion
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_128;
      for (int k = 0; k < 4; k++) key_reg[k] <= '0;
      busy  <= 1'b1;
      ready <= 1'b0;
      widx  <= '0;
      wmod  <= '0;
      ridx  <= 4'd1;
    end else if (cfg_wen && known_reg) begin
      if (cfg_index == REG_MODE) begin
        mode <= (cfg_wdata[1:0] == 2'd3) ? MODE_256 : cfg_wdata[1:0];
      end else begin
        key_reg[2'(cfg_index - REG_KEY0)] <= cfg_wdata;
      end
      busy  <= 1'b1;
      ready <= 1'b0;
      widx  <= '0;
      wmod  <= '0;
      ridx  <= 4'd1;
    end else if (busy) begin
      rk[widx[5:2]][127-32*widx[1:0] -: 32] <= word_new;
      win[0] <= word_new;
      for (int k = 1; k < 8; k++) win[k] <= win[k-1];
      widx <= widx + 6'd1;
      if (widx >= 6'(nk)) begin
        if (wmod == 3'(nk - 4'd1)) begin
          wmod <= '0;
          ridx <= ridx + 4'd1;
        end else begin
          wmod <= wmod + 3'd1;
        end
      end
      if (widx == total - 6'd1) begin
        busy  <= 1'b0;
        ready <= 1'b1;
      end
    end
  end

  assign round_keys   = rk;
  assign status.ready = ready;
  assign status.nr    = nk + 4'd6;

endmodule

// ----- rtl/aes_enc_queue.sv -----
// ----------------------------------------------------------------------------
// AES input queue
// Accepts plaintext blocks once the key is ready and buffers two of them
// ahead of the round pipeline.
// ----------------------------------------------------------------------------
module aes_enc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  aes_enc_pkg::ks_status_t status,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [127:0]            in_data,
  output logic                    out_valid,
  input  logic                    out_pop,
  output logic [127:0]            out_data
);
  import aes_enc_pkg::*;

  logic [127:0] mem [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         push, pop;

  assign in_ready  = status.ready && (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_data  = mem[rd_ptr];

  // Store the transfer
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/aes_enc_pipe.sv -----
// ----------------------------------------------------------------------------
// AES round pipeline
// Initial AddRoundKey and fourteen round stages; stages past the last round
// of the chosen key length pass the state through.
// ----------------------------------------------------------------------------
module aes_enc_pipe (
  input  logic                    clk,
  input  logic                    rst,
  input  aes_enc_pkg::rkeys_t     round_keys,
  input  aes_enc_pkg::ks_status_t status,
  input  logic                    in_valid,
  output logic                    in_pop,
  input  logic [127:0]            in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [127:0]            out_data
);
  import aes_enc_pkg::*;

  localparam int unsigned LAST = NUM_RKEYS - 1;

  logic [127:0]  st [NUM_RKEYS];
  logic [LAST:0] vld;
  logic          adv;

  // Whole pipe moves unless the finished block is stalled
  assign adv    = !vld[LAST] || out_ready;
  assign in_pop = adv;

  // Initial key add
  always_ff @(posedge clk) begin
    if (adv) st[0] <= in_data ^ round_keys[0];
  end

  // Round stages
  for (genvar s = 1; s < NUM_RKEYS; s++) begin : g_round
    logic [127:0] ss, nxt;
    always_comb begin
      ss = sub_shift(st[s-1]);
      if (4'(s) < status.nr) begin
        nxt = mix_columns(ss) ^ round_keys[s];
      end else if (4'(s) == status.nr) begin
        nxt = ss ^ round_keys[s];
      end else begin
        nxt = st[s-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) st[s] <= nxt;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  assign out_valid = vld[LAST];
  assign out_data  = st[LAST];

endmodule

// ----- rtl/aes_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// AES block encrypt
// AES-128/192/256 encryption of 128-bit blocks with an on-chip key schedule.
//
// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid/tready    tdata: plaintext_high, plaintext_low
// m_axis    out  tvalid/tready    tdata: ciphertext_high, ciphertext_low
// cfg       in   cfg_wen          cfg_index, cfg_wdata
//
// One block per cycle unless the output stalls or the key expands; blocks pass
// the queue, the key add and 14 rounds. Reset and each write to a known register
// start the key expansion: one schedule word per cycle, 44/52/60 words for
// 128/192/256-bit keys, s_axis_tready low meanwhile. A stalled output holds the
// whole round pipeline; the two-entry queue keeps taking blocks until full.
// ----------------------------------------------------------------------------
module aes_block_encrypt (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // plaintext_high [63:0], plaintext_low [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata   // ciphertext_high [63:0], ciphertext_low [127:64]
);
  import aes_enc_pkg::*;

  rkeys_t       round_keys;
  ks_status_t   status;
  logic         q_valid, q_pop;
  logic [127:0] q_data, ct;

  aes_enc_key_sched u_key_sched (
    .clk, .rst, .cfg_wen, .cfg_index, .cfg_wdata,
    .round_keys, .status
  );

  // Byte 0 of the state on top
  aes_enc_queue u_queue (
    .clk, .rst, .status,
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_data  (q_data)
  );

  aes_enc_pipe u_pipe (
    .clk, .rst, .round_keys, .status,
    .in_valid  (q_valid),
    .in_pop    (q_pop),
    .in_data   (q_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (ct)
  );

  assign m_axis_tdata = {ct[63:0], ct[127:64]};

endmodule

// ----- rtl/aes_enc_checker.sv -----
// ----------------------------------------------------------------------------
// AES encrypt checker
// Port-level checks of the AES encrypt block, bound to the top level.
// ----------------------------------------------------------------------------
`include "aes_block_encrypt_macros.svh"

module aes_enc_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_wen,
  input logic [2:0]   cfg_index,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  import aes_enc_pkg::*;

  // Stalled result holds
  `AES_ENC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output changed")

  // A write to a known register blocks input while the schedule is rebuilt
  `AES_ENC_ASSERT_NEXT(a_cfg_block, cfg_wen && cfg_index <= REG_KEY3, !s_axis_tready, "input taken during key expansion")

  // Reset empties the pipe and starts expansion
  `AES_ENC_ASSERT_ALWAYS(a_rst_idle, rst, !m_axis_tvalid && !s_axis_tready, "block not idle after reset")

endmodule

bind aes_block_encrypt aes_enc_checker u_checker (
  .clk, .rst, .cfg_wen, .cfg_index, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);

// ----- sim/aes_block_encrypt_tb.sv -----
// ----------------------------------------------------------------------------
// AES block encrypt testbench
// Drives plaintext blocks and key/mode register writes into the encrypt
// block, predicts every ciphertext with a behavioral AES model and checks
// each output transfer in order. Directed known-answer rows come first,
// then random keys, modes and blocks with random gaps and output stalls.
// ----------------------------------------------------------------------------
module aes_block_encrypt_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_enc_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] REG_BAD     = 3'd5;
  localparam logic [2:0] REG_BAD_TOP = 3'd7;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] wdata;
    logic [63:0] pt_hi;
    logic [63:0] pt_lo;
    bit          known;
    logic [63:0] ct_hi;
    logic [63:0] ct_lo;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  bit           failed = 1'b0;
  block_t       ct_pending[$];

  // Predictor state: own copy of the registers and the key schedule
  logic [7:0]   sbox_lut [256];
  logic [1:0]   mdl_mode;
  logic [63:0]  mdl_key [4];
  logic [31:0]  mdl_sched [60];
  bit           mdl_sched_ok;

  aes_block_encrypt DUT (.*);

  always #4 clk = ~clk;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // Build the S-box from the field inverse and the affine map
  task automatic build_sbox();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = '0;
      for (int y = 1; y < 256; y++) begin
        if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox_lut[x] = s;
    end
  endtask

  function automatic logic [31:0] subst_word(input logic [31:0] w);
    return {sbox_lut[w[31:24]], sbox_lut[w[23:16]], sbox_lut[w[15:8]], sbox_lut[w[7:0]]};
  endfunction

  function automatic int words_of_key();
    return (mdl_mode == MODE_128) ? 4 : (mdl_mode == MODE_192) ? 6 : 8;
  endfunction

  task automatic expand_schedule();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = words_of_key();
    total = 4 * (nk + 7);
    for (int i = 0; i < nk; i++)
      mdl_sched[i] = i[0] ? mdl_key[i/2][31:0] : mdl_key[i/2][63:32];
    for (int i = nk; i < total; i++) begin
      t = mdl_sched[i-1];
      if (i % nk == 0) begin
        rc = 8'h01;
        for (int k = 1; k < i / nk; k++) rc = gf_mul(rc, 8'h02);
        t = subst_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
      end else if (nk > 6 && i % nk == 4) begin
        t = subst_word(t);
      end
      mdl_sched[i] = mdl_sched[i-nk] ^ t;
    end
    mdl_sched_ok = 1'b1;
  endtask

  function automatic void mix_key(ref logic [7:0] st [16], input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        st[4*c+r] ^= mdl_sched[rnd*4+c][31-8*r -: 8];
  endfunction

  // Encrypt one block with the current predictor schedule
  task automatic encrypt_block(input block_t pt, output block_t ct);
    logic [7:0] st [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3;
    int nr;
    if (!mdl_sched_ok) expand_schedule();
    nr = words_of_key() + 6;
    for (int i = 0; i < 8; i++) begin
      st[i]   = pt.hi[63-8*i -: 8];
      st[8+i] = pt.lo[63-8*i -: 8];
    end
    mix_key(st, 0);
    for (int rnd = 1; rnd <= nr; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[4*c+r] = sbox_lut[st[4*((c+r)%4)+r]];
      st = t;
      if (rnd < nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
          st[4*c]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
          st[4*c+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
          st[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
          st[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
        end
      end
      mix_key(st, rnd);
    end
    for (int i = 0; i < 8; i++) begin
      ct.hi[63-8*i -: 8] = st[i];
      ct.lo[63-8*i -: 8] = st[8+i];
    end
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Write one register once every pending result has come out
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    while (ct_pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wen = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wen = 1'b0;
    if (idx == REG_MODE) begin
      mdl_mode = (val[1:0] == 2'd3) ? MODE_256 : val[1:0];
      mdl_sched_ok = 1'b0;
    end else if (idx >= REG_KEY0 && idx <= REG_KEY3) begin
      mdl_key[2'(idx - REG_KEY0)] = val;
      mdl_sched_ok = 1'b0;
    end
  endtask

  // Offer one block, hold it until the transfer, queue its ciphertext
  task automatic send_block(input block_t pt, input bit known, input block_t ct_known);
    block_t ct;
    int g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {pt.lo, pt.hi};
    do @(posedge clk); while (!s_axis_tready);
    encrypt_block(pt, ct);
    ct_pending.push_back(known ? ct_known : ct);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // Random output stalls
  initial begin
    int g;
    @(negedge clk);
    forever begin
      m_axis_tready = 1'b1;
      repeat ($urandom_range(8, 1)) @(negedge clk);
      g = gap_len();
      if (g != 0) begin
        m_axis_tready = 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // Check each ciphertext transfer against the oldest prediction
  always @(posedge clk) begin
    block_t exp_ct;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (ct_pending.size() == 0) begin
        $error("unexpected ciphertext transfer %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        exp_ct = ct_pending.pop_front();
        if (m_axis_tdata[63:0] !== exp_ct.hi) begin
          $error("ciphertext_high expected %h actual %h", exp_ct.hi, m_axis_tdata[63:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[127:64] !== exp_ct.lo) begin
          $error("ciphertext_low expected %h actual %h", exp_ct.lo, m_axis_tdata[127:64]);
          failed = 1'b1;
        end
      end
    end
  end

  // Main stimulus
  initial begin
    row_t   rows[$];
    block_t pt, ck;
    int     mode_pick;
    mdl_mode = MODE_128;
    for (int i = 0; i < 4; i++) mdl_key[i] = '0;
    mdl_sched_ok = 1'b0;
    build_sbox();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Known-answer rows: zero key after reset, then the standard vectors
    rows = '{
      '{0, 0, 0, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e},
      '{1, REG_KEY0, 64'h0001020304050607, 0, 0, 0, 0, 0},
      '{1, REG_KEY0 + 3'd1, 64'h08090a0b0c0d0e0f, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff,
        1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{0, 0, 0, 64'hffffffffffffffff, 64'hffffffffffffffff, 0, 0, 0},
      '{0, 0, 0, 64'h0, 64'h0, 0, 0, 0},
      '{1, REG_KEY0 + 3'd2, 64'h1011121314151617, 0, 0, 0, 0, 0},
      '{1, REG_KEY3, 64'h18191a1b1c1d1e1f, 0, 0, 0, 0, 0},
      // longer key registers do not matter for a 128-bit key
      '{0, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff,
        1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
      '{1, REG_MODE, 64'd1, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff,
        1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191},
      '{1, REG_MODE, 64'd2, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff,
        1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
      // mode three behaves as a 256-bit key
      '{1, REG_MODE, 64'd3, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff,
        1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
      // unknown register indexes leave the key alone
      '{1, REG_BAD, 64'hffffffffffffffff, 0, 0, 0, 0, 0},
      '{1, REG_BAD_TOP, 64'hffffffffffffffff, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64'h0011223344556677, 64'h8899aabbccddeeff,
        1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089},
      '{1, REG_KEY0, 64'hffffffffffffffff, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64'hffffffffffffffff, 64'h0, 0, 0, 0},
      '{1, REG_MODE, 64'hfffffffffffffffc, 0, 0, 0, 0, 0},
      '{0, 0, 0, 64'h0, 64'hffffffffffffffff, 0, 0, 0}
    };
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        write_reg(rows[i].idx, rows[i].wdata);
      end else begin
        pt.hi = rows[i].pt_hi;
        pt.lo = rows[i].pt_lo;
        ck.hi = rows[i].ct_hi;
        ck.lo = rows[i].ct_lo;
        send_block(pt, rows[i].known, ck);
      end
    end

    // Random phases: new key and mode, then a burst of blocks
    ck = '{default: '0};
    for (int ph = 0; ph < 12; ph++) begin
      mode_pick = (ph < 4) ? ph : $urandom_range(3);
      for (int k = 0; k < 4; k++) write_reg(REG_KEY0 + k[2:0], rand64());
      if ($urandom_range(3) == 0) write_reg(3'(REG_BAD + $urandom_range(2)), rand64());
      write_reg(REG_MODE, {$urandom, $urandom} & ~64'd3 | 64'(mode_pick));
      repeat ($urandom_range(50, 25)) begin
        pt.hi = rand64();
        pt.lo = rand64();
        send_block(pt, 1'b0, ck);
      end
    end

    // Drain and report
    while (ct_pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
